### sv/sorc_pkg.sv
`default_nettype none

package sorc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 8;
  localparam int unsigned TermW = 16;
  localparam int unsigned ProdW = 25;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [TermW-1:0] term_t;
  typedef logic [ProdW-1:0] prod_t;

  localparam term_t TermMod     = 16'hFFFF;
  localparam term_t FirstOffset = 16'd7;
  localparam pos_t  AlphaMul    = 8'd17;
  localparam pos_t  BetaMul     = 8'd31;

  // x mod 65535 using 2^16 == 1, valid for x below 2^25
  function automatic term_t fold_mod(input prod_t x);
    logic [TermW:0] s;
    logic [TermW:0] m;
    s = {8'd0, x[ProdW-1:TermW]} + {1'b0, x[TermW-1:0]};
    if (s >= {1'b0, TermMod}) begin
      m = s - {1'b0, TermMod};
    end else begin
      m = s;
    end
    return m[TermW-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/second_order_recurrence_checksum_unit.sv
`default_nettype none

// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     data_byte_i, first_i, last_i
// out      output     out_valid_o / out_ready_i   checksum_o
//
// One byte per cycle while in_ready_o is high; the recurrence (9x16 and
// 8x16 multiplies, subtract, mod 65535 fold) closes in the accept cycle.
// A result goes to the output register, or to the skid entry when it is held.
// A two-entry output buffer keeps input flowing while a result waits;
// in_ready_o drops only when both entries are held.
// Reset clears the recurrence state to prev 1, curr 0, position 0.

module second_order_recurrence_checksum_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire sorc_pkg::byte_t data_byte_i,
  input  wire                  first_i,
  input  wire                  last_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output sorc_pkg::term_t      checksum_o
);
  import sorc_pkg::*;

  term_t prev_q, prev_d;
  term_t curr_q, curr_d;
  pos_t  pos_q, pos_d;

  logic  out_valid_q, out_valid_d;
  term_t out_data_q, out_data_d;
  logic  skid_valid_q, skid_valid_d;
  term_t skid_data_q, skid_data_d;

  logic [2*PosW-1:0] alpha_prod, beta_prod;
  pos_t              alpha, beta;
  logic [ByteW:0]    coef;
  prod_t             prod_a, prod_b, diff;
  logic              a_ge_b;
  term_t             red;
  logic [TermW:0]    neg_val;
  term_t             next_term;

  logic accept, push, pop;

  assign accept = in_valid_i & in_ready_o;
  assign push   = accept & last_i;
  assign pop    = out_valid_q & out_ready_i;

  assign alpha_prod = {8'd0, pos_q} * {8'd0, AlphaMul};
  assign beta_prod  = {8'd0, pos_q} * {8'd0, BetaMul};
  assign alpha      = alpha_prod[PosW-1:0];
  assign beta       = beta_prod[PosW-1:0];
  assign coef       = {1'b0, data_byte_i} + {1'b0, alpha};
  assign prod_a     = {16'd0, coef} * {9'd0, curr_q};
  assign prod_b     = {17'd0, beta} * {9'd0, prev_q};
  assign a_ge_b     = prod_a >= prod_b;
  assign diff       = a_ge_b ? (prod_a - prod_b) : (prod_b - prod_a);
  assign red        = fold_mod(diff);
  assign neg_val    = {1'b0, TermMod} + 17'd1 - {1'b0, red};

  // negative side: (1 - d) mod 65535
  always_comb begin
    if (a_ge_b) begin
      next_term = red;
    end else if (red == 16'd0) begin
      next_term = 16'd1;
    end else if (red == 16'd1) begin
      next_term = 16'd0;
    end else begin
      next_term = neg_val[TermW-1:0];
    end
  end

  always_comb begin
    prev_d = prev_q;
    curr_d = curr_q;
    pos_d  = pos_q;
    if (accept) begin
      if (first_i) begin
        prev_d = 16'd1;
        curr_d = {8'd0, data_byte_i} + FirstOffset;
        pos_d  = 8'd1;
      end else begin
        prev_d = curr_q;
        curr_d = next_term;
        pos_d  = pos_q + 8'd1;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_d = 1'b1;
        skid_data_d  = curr_d;
      end else begin
        out_valid_d = 1'b1;
        out_data_d  = curr_d;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= 16'd1;
      curr_q       <= 16'd0;
      pos_q        <= 8'd0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      prev_q       <= prev_d;
      curr_q       <= curr_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign checksum_o  = out_data_q;

endmodule

`default_nettype wire
